>>> hw/rtl/kal_pkg.sv
// Shared types and constants for the binary-lifting ancestor block.
`default_nettype none

package kal_pkg;

  localparam int NODE_W = 10;
  localparam int STEP_W = 10;
  localparam int FUNC_W = 2;

  localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 10'd1023;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_QUERY = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_B_RD1,
    S_B_RD2,
    S_B_WR,
    S_Q_ISSUE,
    S_Q_WAIT,
    S_Q_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_BUILD_SELF,
    RD_BUILD_MID,
    RD_QUERY
  } rd_sel_t;

  typedef struct packed {
    logic    write_parent;
    logic    start_build;
    logic    start_query;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    build_wr;
    logic    x_update;
    logic    lvl_dec;
    logic    build_adv;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic build_empty;
    logic over;
    logic bit_set;
    logic lvl_zero;
    logic idx_last;
    logic lvl_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/kal_ctrl.sv
// Controller state machine that sequences writes, table builds and queries.
`default_nettype none

module kal_ctrl
  import kal_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] in_func,
  output logic              in_ready,
  input  status_t           st,
  output cmd_t              cmd
);

  state_t state;
  state_t state_next;
  func_t  func;

  assign func = func_t'(in_func);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (func)
            FUNC_BUILD: begin
              if (!st.build_empty) state_next = S_B_RD1;
            end
            FUNC_QUERY: state_next = S_Q_ISSUE;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_B_RD1: state_next = S_B_RD2;
      S_B_RD2: state_next = S_B_WR;
      S_B_WR: begin
        if (st.idx_last && st.lvl_last) state_next = S_IDLE;
        else state_next = S_B_RD1;
      end
      S_Q_ISSUE: begin
        priority if (st.over) state_next = S_Q_DONE;
        else if (st.bit_set) state_next = S_Q_WAIT;
        else if (st.lvl_zero) state_next = S_Q_DONE;
        else state_next = S_Q_ISSUE;
      end
      S_Q_WAIT: begin
        if (st.lvl_zero) state_next = S_Q_DONE;
        else state_next = S_Q_ISSUE;
      end
      S_Q_DONE: begin
        if (!st.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.rd_sel = RD_BUILD_SELF;
    in_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (func)
            FUNC_WRITE: cmd.write_parent = 1'b1;
            FUNC_BUILD: cmd.start_build  = !st.build_empty;
            FUNC_QUERY: cmd.start_query  = 1'b1;
            default:    cmd.write_parent = 1'b0;
          endcase
        end
      end
      S_B_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BUILD_SELF;
      end
      S_B_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BUILD_MID;
      end
      S_B_WR: begin
        cmd.build_wr  = 1'b1;
        cmd.build_adv = 1'b1;
      end
      S_Q_ISSUE: begin
        if (!st.over) begin
          if (st.bit_set) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_QUERY;
          end else if (!st.lvl_zero) begin
            cmd.lvl_dec = 1'b1;
          end
        end
      end
      S_Q_WAIT: begin
        cmd.x_update = 1'b1;
        cmd.lvl_dec  = !st.lvl_zero;
      end
      S_Q_DONE: cmd.out_load = !st.out_busy;
      default:  cmd.out_load = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/kal_datapath.sv
// Datapath with the jump table memory, build counters, climb registers and output register.
`default_nettype none

module kal_datapath
  import kal_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           st,
  input  logic [NODE_W-1:0] in_node,
  input  logic [NODE_W-1:0] in_parent,
  input  logic [STEP_W-1:0] in_step,
  input  logic              cfg_we,
  input  logic [NODE_W-1:0] cfg_wdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] out_ancestor,
  output logic              out_found
);

  localparam int TAB_NODES = (MAX_NODES > (1 << NODE_W)) ? (1 << NODE_W) : MAX_NODES;
  localparam int NAW       = $clog2(TAB_NODES);
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW        = LW + NAW;
  localparam logic [LW-1:0]     TOP_LVL   = LW'(LEVELS - 1);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(TAB_NODES - 1);

  function automatic logic node_ok(input logic [NODE_W-1:0] n);
    node_ok = (n != '0) && (n <= LAST_NODE);
  endfunction

  logic [NODE_W-1:0] mem [0:(1 << AW)-1];
  logic [NODE_W-1:0] mem_q;
  logic              rd_zero;
  logic [NODE_W-1:0] rd_data;
  logic [NODE_W-1:0] rd_node;
  logic [LW-1:0]     rd_lvl;
  logic [AW-1:0]     rd_addr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [NODE_W-1:0] mem_wdata;

  logic [NODE_W-1:0] node_count;
  logic [NODE_W-1:0] last;
  logic [NODE_W-1:0] build_index;
  logic [LW-1:0]     lvl;
  logic [NODE_W-1:0] x;
  logic [STEP_W-1:0] k;
  logic [LEVELS-1:0] k_lvl;
  logic              over;
  logic [NODE_W-1:0] ancestor_q;

  assign rd_data = rd_zero ? '0 : mem_q;
  assign last    = (node_count > LAST_NODE) ? LAST_NODE : node_count;
  assign k_lvl   = LEVELS'(k);

  always_comb begin
    rd_node = build_index;
    rd_lvl  = lvl - LW'(1);
    unique case (cmd.rd_sel)
      RD_BUILD_SELF: begin
        rd_node = build_index;
        rd_lvl  = lvl - LW'(1);
      end
      RD_BUILD_MID: begin
        rd_node = rd_data;
        rd_lvl  = lvl - LW'(1);
      end
      RD_QUERY: begin
        rd_node = x;
        rd_lvl  = lvl;
      end
      default: begin
        rd_node = x;
        rd_lvl  = lvl;
      end
    endcase
    rd_addr = {rd_lvl, rd_node[NAW-1:0]};
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {LW'(0), in_node[NAW-1:0]};
    mem_wdata = in_parent;
    if (cmd.write_parent) begin
      mem_we = node_ok(in_node);
    end else if (cmd.build_wr) begin
      mem_we    = 1'b1;
      mem_waddr = {lvl, build_index[NAW-1:0]};
      mem_wdata = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_en) begin
      mem_q   <= mem[rd_addr];
      rd_zero <= !node_ok(rd_node);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_COUNT_RESET;
      build_index <= '0;
      lvl         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) node_count <= cfg_wdata;
      if (cmd.start_build) begin
        lvl         <= LW'(1);
        build_index <= NODE_W'(1);
      end else if (cmd.build_adv) begin
        if (build_index == last) begin
          if (lvl == TOP_LVL) begin
            lvl         <= '0;
            build_index <= '0;
          end else begin
            lvl         <= lvl + LW'(1);
            build_index <= NODE_W'(1);
          end
        end else begin
          build_index <= build_index + NODE_W'(1);
        end
      end else if (cmd.start_query) begin
        lvl <= TOP_LVL;
      end else if (cmd.lvl_dec) begin
        lvl <= lvl - LW'(1);
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      x    <= node_ok(in_node) ? in_node : '0;
      k    <= in_step;
      over <= (in_step >> LEVELS) != '0;
    end else if (cmd.x_update) begin
      x <= rd_data;
    end
    if (cmd.out_load) ancestor_q <= over ? '0 : x;
  end

  assign out_ancestor = ancestor_q;
  assign out_found    = (ancestor_q != '0);

  always_comb begin
    st.build_empty = (last == '0) || (LEVELS == 1);
    st.over        = over;
    st.bit_set     = k_lvl[lvl];
    st.lvl_zero    = (lvl == '0);
    st.idx_last    = (build_index == last);
    st.lvl_last    = (lvl == TOP_LVL);
    st.out_busy    = out_valid && !out_ready;
  end

  a_no_root_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mem_waddr[NAW-1:0] != '0))
    else $error("jump table write aimed at the root entry");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken result");

  a_build_range: assert property (@(posedge clk) disable iff (rst)
    cmd.build_wr |-> ((build_index != '0) && (build_index <= last) && (lvl != '0)))
    else $error("build counters outside the node range");

endmodule

`default_nettype wire

>>> hw/rtl/kth_ancestor_lifting.sv
// Top level of the binary-lifting k-th ancestor block.
// A write transaction (tuser 0) stores one parent. A build transaction (tuser 1) sweeps
// levels 1 to LEVELS-1 and nodes 1 to min(node_count, MAX_NODES-1), and does nothing when
// node_count is 0; for each node at each level it reads the node's entry, then the entry of
// the node that it points to, then writes the new entry. A query transaction (tuser 2) walks
// the levels down from the top one, with one table lookup for each set bit of step_count. Each
// lookup uses the single-port jump table memory with its registered read and depends on the
// one before. One item is worked on at a time; the next is accepted once the previous one is
// finished, and a finished query result waits in an output register. The table is not
// cleared after reset: an entry must be written before it is read.
`default_nettype none

module kth_ancestor_lifting
  import kal_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // node [9:0], parent_node [19:10], step_count [29:20]
  input  logic [1:0]  s_axis_tuser,  // func [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // ancestor [9:0]
  output logic        m_axis_tuser,  // found [0]
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata
);

  cmd_t              cmd;
  status_t           st;
  logic [NODE_W-1:0] ancestor;

  kal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_func  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  kal_datapath #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .in_node      (s_axis_tdata[9:0]),
    .in_parent    (s_axis_tdata[19:10]),
    .in_step      (s_axis_tdata[29:20]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_ancestor (ancestor),
    .out_found    (m_axis_tuser)
  );

  assign m_axis_tdata = {6'b0, ancestor};

endmodule

`default_nettype wire

>>> tb/ancestor_checker.sv
// Watches both streams and the config port, predicts every query answer and compares it.
module ancestor_checker
  import kal_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // node [9:0], parent_node [19:10], step_count [29:20]
  input  logic [1:0]  s_axis_tuser,  // func [1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,  // ancestor [9:0]
  input  logic        m_axis_tuser,  // found [0]
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,
  output int          mismatches,
  output int          awaiting,
  output int          results_checked,
  output int          builds_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              found;
  } lift_result_t;

  logic [NODE_W-1:0] jump_of [MAX_NODES][LEVELS];
  logic [NODE_W-1:0] span_limit = NODE_COUNT_RESET;
  lift_result_t      answer_q[$];
  int                err_total = 0;
  int                check_total = 0;
  int                build_total = 0;

  initial begin
    mismatches      = 0;
    awaiting        = 0;
    results_checked = 0;
    builds_seen     = 0;
  end

  function automatic logic [NODE_W-1:0] hop(input int n, input int lvl);
    if (n == 0 || n >= MAX_NODES || lvl >= LEVELS) begin
      return '0;
    end
    return jump_of[n][lvl];
  endfunction

  function automatic void rebuild_jumps();
    int                top_node;
    logic [NODE_W-1:0] mid;
    top_node = (int'(span_limit) > MAX_NODES - 1) ? MAX_NODES - 1 : int'(span_limit);
    for (int lvl = 1; lvl < LEVELS; lvl++) begin
      for (int n = 1; n <= top_node; n++) begin
        mid = hop(n, lvl - 1);
        jump_of[n][lvl] = hop(mid, lvl - 1);
      end
    end
  endfunction

  function automatic logic [NODE_W-1:0] climb_ancestor(input int start, input int steps);
    int x;
    int k;
    int weight;
    x = (start >= MAX_NODES) ? 0 : start;
    k = steps;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      weight = 1 << i;
      if (k >= weight) begin
        x = hop(x, i);
        k -= weight;
      end
      if (k == 0) begin
        return NODE_W'(x);
      end
    end
    return (k == 0) ? NODE_W'(x) : '0;
  endfunction

  always @(posedge clk) begin
    lift_result_t      got;
    lift_result_t      want;
    lift_result_t      queued;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] par;
    logic [STEP_W-1:0] steps;
    logic [NODE_W-1:0] predicted;
    if (rst) begin
      span_limit = NODE_COUNT_RESET;
      answer_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.ancestor = m_axis_tdata[NODE_W-1:0];
        got.found    = m_axis_tuser;
        if (answer_q.size() == 0) begin
          $error("result with no query waiting: ancestor %0d, found %0d",
                 got.ancestor, got.found);
          err_total++;
        end else begin
          want = answer_q.pop_front();
          if (got.ancestor !== want.ancestor) begin
            $error("ancestor mismatch: expected %0d, actual %0d", want.ancestor, got.ancestor);
            err_total++;
          end
          if (got.found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, got.found);
            err_total++;
          end
          check_total++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        node  = s_axis_tdata[NODE_W-1:0];
        par   = s_axis_tdata[2*NODE_W-1:NODE_W];
        steps = s_axis_tdata[2*NODE_W+STEP_W-1:2*NODE_W];
        case (s_axis_tuser)
          FUNC_WRITE: begin
            if (node != 0 && int'(node) < MAX_NODES) begin
              jump_of[node][0] = par;
            end
          end
          FUNC_BUILD: begin
            rebuild_jumps();
            build_total++;
          end
          FUNC_QUERY: begin
            predicted       = climb_ancestor(node, steps);
            queued.ancestor = predicted;
            queued.found    = (predicted != '0);
            answer_q        = {answer_q, queued};
          end
          default: ;
        endcase
      end
      if (cfg_we) begin
        span_limit = cfg_wdata;
      end
    end
    mismatches      <= err_total;
    awaiting        <= answer_q.size();
    results_checked <= check_total;
    builds_seen     <= build_total;
  end

endmodule

>>> tb/testbench.sv
// Top of the testbench: clock, reset, stimulus, output pacing, watchdog and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kal_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 150000;
  localparam int HOLD_CYCLES    = 600;
  localparam int PHASE_ITEMS    = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we = 1'b0;
  logic [9:0]  cfg_wdata = '0;

  int   mismatches;
  int   awaiting;
  int   results_checked;
  int   builds_seen;
  int   tx_idle_pct = 6;
  int   rx_idle_pct = 51;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   sent_total = 0;
  int   mid_span = 0;

  kth_ancestor_lifting i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  ancestor_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .awaiting        (awaiting),
    .results_checked (results_checked),
    .builds_seen     (builds_seen)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_taken    <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic offer(input logic [FUNC_W-1:0] func, input int node, input int par,
                       input int steps);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {2'b00, STEP_W'(steps), NODE_W'(par), NODE_W'(node)};
    do @(posedge clk); while (!s_axis_tready);
    sent_total++;
  endtask

  function automatic int pick_steps();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15);
      1: return $urandom_range(16, 255);
      2: return $urandom_range(256, 1023);
      3: return 1 << $urandom_range(0, 9);
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  function automatic int pick_parent(input int node);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0 || node == 0) begin
      return 0;
    end
    if (r <= 2) begin
      return $urandom_range(0, 1023);
    end
    return (node > 4) ? node - $urandom_range(1, 4) : $urandom_range(0, node - 1);
  endfunction

  // A query goes last so that the block is idle once its answer is back.
  task automatic reconfigure(input int span);
    offer(FUNC_QUERY, $urandom_range(1, 1023), 0, pick_steps());
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= 10'(span);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_phase(input int count, input int build_permil);
    int pick;
    int node;
    repeat (count) begin
      pick = $urandom_range(0, 999);
      node = $urandom_range(0, 1023);
      if (pick < build_permil) begin
        offer(FUNC_BUILD, node, $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else if (pick < build_permil + 10) begin
        offer(FUNC_UNUSED, node, $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else if (pick < 450) begin
        offer(FUNC_WRITE, node, pick_parent(node), $urandom_range(0, 1023));
      end else begin
        offer(FUNC_QUERY, node, $urandom_range(0, 1023), pick_steps());
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every node from 1 to 1023 gets a parent before anything reads the table.
    for (int n = 1; n < 1024; n++) begin
      offer(FUNC_WRITE, n,
            ($urandom_range(0, 299) == 0 || n <= 3) ? 0 : n - $urandom_range(1, 3),
            $urandom_range(0, 1023));
    end
    offer(FUNC_BUILD, 0, 0, 0);

    offer(FUNC_WRITE, 0, 5, 0);
    offer(FUNC_QUERY, 0, 0, 0);
    offer(FUNC_QUERY, 0, 0, 1023);
    offer(FUNC_QUERY, 1023, 0, 0);
    offer(FUNC_QUERY, 1, 0, 0);
    offer(FUNC_QUERY, 1, 0, 1);
    offer(FUNC_QUERY, 1, 0, 5);
    offer(FUNC_QUERY, 1023, 0, 1);
    offer(FUNC_QUERY, 1023, 0, 511);
    offer(FUNC_QUERY, 1023, 0, 512);
    offer(FUNC_QUERY, 1023, 0, 1023);
    offer(FUNC_UNUSED, 1023, 1023, 1023);
    offer(FUNC_WRITE, 1023, 1023, 0);
    offer(FUNC_WRITE, 512, 1023, 0);
    offer(FUNC_QUERY, 1023, 0, 1);
    offer(FUNC_QUERY, 512, 0, 3);
    offer(FUNC_BUILD, 0, 0, 0);
    offer(FUNC_QUERY, 1023, 0, 1023);
    offer(FUNC_QUERY, 512, 0, 1023);
    reconfigure(0);
    offer(FUNC_BUILD, 0, 0, 0);
    reconfigure(1023);

    random_phase(PHASE_ITEMS, 5);
    reconfigure(1);
    tx_idle_pct = 51;
    rx_idle_pct <= 6;
    random_phase(PHASE_ITEMS, 40);
    mid_span = $urandom_range(2, 1022);
    reconfigure(mid_span);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req    <= 1'b1;
    random_phase(PHASE_ITEMS, 8);
    offer(FUNC_QUERY, $urandom_range(1, 1023), 0, pick_steps());
    s_axis_tvalid <= 1'b0;

    do @(posedge clk); while (awaiting != 0);
    repeat (40) @(posedge clk);

    $display("Covered %0d transactions, %0d query answers and %0d table builds,",
             sent_total, results_checked, builds_seen);
    $display("under three pacing modes, one long output stall, node_count 0, 1, %0d, 1023.",
             mid_span);
    if (mismatches == 0 && awaiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
